// ----- sv/omp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// omp_pkg: shared types and constants of the ordered map pop min/max block
// Holds the store capacity, status and action codes and the word structs
// used between the top level, the cell chain and the cells.
// ----------------------------------------------------------------------------
package omp_pkg;

	// number of cells in the chain
	localparam int CAPACITY = 64;

	// operation codes of an input word
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// action broadcast to every cell in the update cycle
	typedef logic [2:0] act_t;
	localparam act_t ACT_NONE   = 3'd0;
	localparam act_t ACT_INSERT = 3'd1;
	localparam act_t ACT_DELETE = 3'd2;
	localparam act_t ACT_UPDATE = 3'd3;
	localparam act_t ACT_POPMIN = 3'd4;
	localparam act_t ACT_POPMAX = 3'd5;

	typedef struct packed {
		logic              op;
		logic signed [31:0] in_key;
		logic signed [31:0] in_data;
	} in_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] out_key;
		logic signed [31:0] out_data;
	} out_word_t;

	// contents one cell shows to its neighbors
	typedef struct packed {
		logic               valid;
		logic signed [31:0] key;
		logic signed [31:0] data;
	} cell_link_t;

	// summary of the chain seen by the control
	typedef struct packed {
		logic               found;
		logic               full;
		logic               empty;
		logic signed [31:0] pop_key;
		logic signed [31:0] pop_data;
	} chain_stat_t;

endpackage
`default_nettype wire

// ----- sv/omp_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// omp_cell: one place of the sorted key/data chain
// Compares its key against the command key, then in the update cycle keeps
// its pair, takes the new pair or new data, takes the pair of its left or
// right neighbor, or drops its pair, so the chain stays sorted with the valid
// places packed at the low end.
// ----------------------------------------------------------------------------
module omp_cell (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cmp_en,
	input  wire                         upd_en,
	input  wire omp_pkg::act_t          act,
	input  wire logic signed [31:0]     cmd_key,
	input  wire logic signed [31:0]     cmd_data,
	input  wire omp_pkg::cell_link_t    left,
	input  wire                         left_less,
	input  wire omp_pkg::cell_link_t    right,
	output omp_pkg::cell_link_t         self,
	output logic                        less,
	output logic                        eq,
	output logic                        last
);
	import omp_pkg::*;

	logic               valid_q;
	logic signed [31:0] key_q;
	logic signed [31:0] data_q;
	logic               less_q;
	logic               eq_q;
	cell_link_t         nxt;
	logic               load;

	assign self = '{valid: valid_q, key: key_q, data: data_q};
	assign less = less_q;
	assign eq   = eq_q;
	assign last = valid_q && !right.valid;

	// register key compare against the command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			less_q <= 1'b0;
			eq_q   <= 1'b0;
		end else if (cmp_en) begin
			less_q <= valid_q && (key_q < cmd_key);
			eq_q   <= valid_q && (key_q == cmd_key);
		end
	end

	// pick next contents from the broadcast action
	always_comb begin
		nxt  = self;
		load = 1'b0;
		case (act)
			ACT_INSERT: begin
				if (!less_q) begin
					load = 1'b1;
					nxt  = left_less ?
						cell_link_t'{valid: 1'b1, key: cmd_key, data: cmd_data} : left;
				end
			end
			ACT_DELETE: begin
				if (!less_q) begin
					load = 1'b1;
					nxt  = right;
				end
			end
			ACT_UPDATE: begin
				if (eq_q) begin
					load     = 1'b1;
					nxt.data = cmd_data;
				end
			end
			ACT_POPMIN: begin
				load = 1'b1;
				nxt  = right;
			end
			ACT_POPMAX: begin
				if (last) begin
					load      = 1'b1;
					nxt.valid = 1'b0;
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// hold or advance valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd_en && load) begin
			valid_q <= nxt.valid;
		end
	end

	// hold or advance pair
	always_ff @(posedge clk) begin
		if (upd_en && load) begin
			key_q  <= nxt.key;
			data_q <= nxt.data;
		end
	end

endmodule
`default_nettype wire

// ----- sv/omp_chain.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// omp_chain: row of sorted cells with their summary logic
// Links every cell to its neighbors, collects the key match, fill and empty
// flags, and captures the pair at the chosen end in the compare cycle.
// ----------------------------------------------------------------------------
module omp_chain (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cmp_en,
	input  wire                         upd_en,
	input  wire omp_pkg::act_t          act,
	input  wire logic signed [31:0]     cmd_key,
	input  wire logic signed [31:0]     cmd_data,
	input  wire                         pop_max,
	output omp_pkg::chain_stat_t        stat
);
	import omp_pkg::*;

	cell_link_t         link_w [CAPACITY];
	logic [CAPACITY-1:0] less_w;
	logic [CAPACITY-1:0] eq_w;
	logic [CAPACITY-1:0] last_w;
	logic signed [31:0] max_key;
	logic signed [31:0] max_data;
	logic signed [31:0] pop_key_q;
	logic signed [31:0] pop_data_q;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			cell_link_t left_l;
			cell_link_t right_l;
			logic       left_less_l;

			if (i == 0) begin : g_first
				assign left_l      = '0;
				assign left_less_l = 1'b1;
			end else begin : g_mid
				assign left_l      = link_w[i-1];
				assign left_less_l = less_w[i-1];
			end

			if (i == CAPACITY - 1) begin : g_end
				assign right_l = '0;
			end else begin : g_nxt
				assign right_l = link_w[i+1];
			end

			omp_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmp_en    (cmp_en),
				.upd_en    (upd_en),
				.act       (act),
				.cmd_key   (cmd_key),
				.cmd_data  (cmd_data),
				.left      (left_l),
				.left_less (left_less_l),
				.right     (right_l),
				.self      (link_w[i]),
				.less      (less_w[i]),
				.eq        (eq_w[i]),
				.last      (last_w[i])
			);
		end
	endgenerate

	// select the last valid pair, one-hot over the cells
	always_comb begin
		max_key  = '0;
		max_data = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			max_key  = max_key  | (last_w[k] ? link_w[k].key  : 32'sd0);
			max_data = max_data | (last_w[k] ? link_w[k].data : 32'sd0);
		end
	end

	// capture the end pair while the chain is steady
	always_ff @(posedge clk) begin
		if (cmp_en) begin
			pop_key_q  <= pop_max ? max_key  : link_w[0].key;
			pop_data_q <= pop_max ? max_data : link_w[0].data;
		end
	end

	assign stat.found    = |eq_w;
	assign stat.full     = link_w[CAPACITY-1].valid;
	assign stat.empty    = !link_w[0].valid;
	assign stat.pop_key  = pop_key_q;
	assign stat.pop_data = pop_data_q;

endmodule
`default_nettype wire

// ----- sv/ordered_map_pop_min_max_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_map_pop_min_max_top: sorted key/data store with end pops
// Keeps up to CAPACITY signed key/data pairs in key order in a chain of
// cells and answers every word with one result word.
// ----------------------------------------------------------------------------
// Each input word passes through a compare phase, in which every cell compares
// its key with the word's key, and an update phase, in which the whole chain
// shifts, inserts, deletes, updates or pops. The next word is taken in the
// update cycle of the one before, and a result is loaded into the output
// register at the end of its word's update cycle. Results wait in that
// register while out_stall is high; the update cycle waits while the register
// is full and out_stall is high. pop_from_max may be written only while no
// word is in flight.
// ----------------------------------------------------------------------------
module ordered_map_pop_min_max_top (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire                  cfg_wdata,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire omp_pkg::in_word_t  in_word,
	output logic                 out_valid,
	input  wire                  out_stall,
	output omp_pkg::out_word_t   out_word
);
	import omp_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_CMP  = 2'd1;
	localparam logic [1:0] PH_UPD  = 2'd2;

	logic [1:0]  ph_q;
	logic        pop_max_q;
	in_word_t    cmd_q;
	out_word_t   out_word_q;
	logic        out_valid_q;
	logic        in_acc;
	logic        upd_go;
	act_t        act;
	chain_stat_t stat;
	out_word_t   res;

	assign upd_go   = (ph_q == PH_UPD) && (!out_valid_q || !out_stall);
	assign in_stall = !((ph_q == PH_IDLE) || upd_go);
	assign in_acc   = in_valid && !in_stall;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_max_q <= 1'b0;
		end else if (cfg_we) begin
			pop_max_q <= cfg_wdata;
		end
	end

	// advance the phase of the word in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
		end else begin
			case (ph_q)
				PH_IDLE: if (in_acc) ph_q <= PH_CMP;
				PH_CMP:  ph_q <= PH_UPD;
				PH_UPD: begin
					if (upd_go) ph_q <= in_acc ? PH_CMP : PH_IDLE;
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	// hold the accepted word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= in_word;
		end
	end

	// decode the chain action and the result
	always_comb begin
		act = ACT_NONE;
		res = '{status: ST_OK, out_key: 32'sd0, out_data: 32'sd0};
		if (cmd_q.op == OP_READ) begin
			if (stat.empty) begin
				res.status = ST_EMPTY;
			end else begin
				act          = pop_max_q ? ACT_POPMAX : ACT_POPMIN;
				res.out_key  = stat.pop_key;
				res.out_data = stat.pop_data;
			end
		end else if (stat.found) begin
			act = (cmd_q.in_data == 32'sd0) ? ACT_DELETE : ACT_UPDATE;
		end else if (cmd_q.in_data != 32'sd0) begin
			if (stat.full) begin
				res.status = ST_FULL;
			end else begin
				act = ACT_INSERT;
			end
		end
	end

	omp_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmp_en   (ph_q == PH_CMP),
		.upd_en   (upd_go),
		.act      (act),
		.cmd_key  (cmd_q.in_key),
		.cmd_data (cmd_q.in_data),
		.pop_max  (pop_max_q),
		.stat     (stat)
	);

	// output word valid: set on update, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			out_word_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// a result only comes out of an update cycle
	a_out_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ph_q == PH_UPD))
		else $error("result word without update cycle");

	// a word is taken only when idle or while the previous one retires
	a_acc_phase: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (ph_q == PH_IDLE || upd_go))
		else $error("word taken while a compare is pending");

	// compare is always followed by the update phase
	a_cmp_upd: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_CMP |=> ph_q == PH_UPD)
		else $error("compare not followed by update");

	// packed valid prefix: store cannot be both empty and full
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.empty && stat.full))
		else $error("chain valid bits not packed");

	// an insert never meets a full chain
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && act == ACT_INSERT) |-> !stat.full)
		else $error("insert into full chain");

endmodule
`default_nettype wire

// ----- verif/omp_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// omp_checker: result checker for the ordered map pop min/max block
// Watches the input, output and register ports, keeps a sorted shadow of the
// store, predicts one result word per accepted input word and compares every
// accepted result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module omp_checker (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire                 cfg_wdata,
	input  wire                 in_valid,
	input  wire                 in_stall,
	input  wire omp_pkg::in_word_t  in_word,
	input  wire                 out_valid,
	input  wire                 out_stall,
	input  wire omp_pkg::out_word_t out_word,
	output int                  fail_count,
	output int                  pending,
	output int                  word_count,
	output int                  pop_count,
	output int                  empty_count,
	output int                  full_count
);
	import omp_pkg::*;

	// stop printing after this many mismatch lines, keep counting
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic signed [31:0] key;
		logic signed [31:0] data;
	} pair_t;

	pair_t     shadow_map[$];
	logic      pop_max;
	out_word_t results_due[$];
	out_word_t oldest_due;

	// print one mismatch line and count it
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		fail_count++;
		if (fail_count <= PRINT_LIMIT)
			$display("%0t: %s: got %h, want %h", $time, what, got, want);
	endtask

	// apply one input word to the shadow store and return its result word
	function automatic out_word_t next_result(in_word_t w);
		out_word_t r;
		pair_t     p;
		int        pos;
		r = '0;
		r.status = ST_OK;
		if (w.op == OP_READ) begin
			if (shadow_map.size() == 0) begin
				r.status = ST_EMPTY;
				empty_count++;
			end else begin
				pos = pop_max ? shadow_map.size() - 1 : 0;
				r.out_key = shadow_map[pos].key;
				r.out_data = shadow_map[pos].data;
				shadow_map.delete(pos);
				pop_count++;
			end
		end else begin
			// find the first entry whose key is not below the word's key
			pos = 0;
			while (pos < shadow_map.size() &&
					$signed(shadow_map[pos].key) < $signed(w.in_key))
				pos++;
			if (pos < shadow_map.size() && shadow_map[pos].key == w.in_key) begin
				if (w.in_data == 0) begin
					shadow_map.delete(pos);
				end else begin
					p = shadow_map[pos];
					p.data = w.in_data;
					shadow_map[pos] = p;
				end
			end else if (w.in_data != 0) begin
				if (shadow_map.size() >= CAPACITY) begin
					r.status = ST_FULL;
					full_count++;
				end else begin
					p.key = w.in_key;
					p.data = w.in_data;
					shadow_map.insert(pos, p);
				end
			end
		end
		return r;
	endfunction

	// compare results, then queue predictions, then track the register
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_map.delete();
			results_due.delete();
			pop_max = 1'b0;
			fail_count = 0;
			pending = 0;
			word_count = 0;
			pop_count = 0;
			empty_count = 0;
			full_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					report_mismatch("result word with nothing due, key", out_word.out_key, '0);
				end else begin
					oldest_due = results_due.pop_front();
					if (out_word.status != oldest_due.status)
						report_mismatch("status", {30'd0, out_word.status},
							{30'd0, oldest_due.status});
					if (out_word.out_key != oldest_due.out_key)
						report_mismatch("out_key", out_word.out_key, oldest_due.out_key);
					if (out_word.out_data != oldest_due.out_data)
						report_mismatch("out_data", out_word.out_data, oldest_due.out_data);
				end
			end
			if (in_valid && !in_stall) begin
				results_due.push_back(next_result(in_word));
				word_count++;
			end
			if (cfg_we)
				pop_max = cfg_wdata;
			pending = results_due.size();
		end
	end

endmodule
`default_nettype wire

// ----- verif/tb_ordered_map_pop_min_max_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_ordered_map_pop_min_max_top: testbench of the ordered map pop min/max top
// Drives directed and random write/read words with random gaps and output
// stalls under both pop directions; a checker beside the block predicts and
// compares every result word, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_ordered_map_pop_min_max_top;
	import omp_pkg::*;

	localparam int PHASES        = 8;
	localparam int PHASE_WORDS   = 155;
	localparam int POOL_SIZE     = 96;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int LIMIT_CYCLES  = 100000;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic      cfg_wdata;
	logic      in_valid;
	logic      in_stall;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_stall;
	out_word_t out_word;

	int fail_count;
	int pending;
	int word_count;
	int pop_count;
	int empty_count;
	int full_count;

	// shared stimulus knobs: no idling on either side, one long output hold
	logic quiet;
	logic hold_req;

	logic signed [31:0] key_pool [POOL_SIZE];
	int read_pct [PHASES] = '{10, 45, 80, 30, 10, 50, 85, 40};

	ordered_map_pop_min_max_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	omp_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word),
		.fail_count  (fail_count),
		.pending     (pending),
		.word_count  (word_count),
		.pop_count   (pop_count),
		.empty_count (empty_count),
		.full_count  (full_count)
	);

	// clock: period 8
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// offer one word after a random gap, hold it until taken
	task automatic send_word(input logic op, input logic signed [31:0] key,
			input logic signed [31:0] data);
		int       gap;
		in_word_t w;
		gap = quiet ? 0 : $urandom_range(0, 3);
		w.op = op;
		w.in_key = key;
		w.in_data = data;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid, wait for every due result, then let the block settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// write the pop direction register; only called while idle
	task automatic write_pop_max(input logic v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly keys from a small pool so that writes hit stored entries
	function automatic logic signed [31:0] pick_key();
		if ($urandom_range(0, 3) != 0)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom;
	endfunction

	// zero data deletes; otherwise any nonzero value
	function automatic logic signed [31:0] pick_data();
		logic signed [31:0] v;
		if ($urandom_range(0, 99) < 15)
			return '0;
		v = $urandom;
		if (v == 0)
			v = 1;
		return v;
	endfunction

	task automatic run_phase(input int words, input int pct);
		for (int i = 0; i < words; i++) begin
			if ($urandom_range(0, 99) < pct)
				send_word(OP_READ, $urandom, $urandom);
			else
				send_word(OP_WRITE, pick_key(), pick_data());
		end
	endtask

	// output side: stall for a randomly drawn number of cycles before each result word,
	// and once for a long stretch when asked
	initial begin : result_sink
		int   n;
		logic hold_done;
		out_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				n = LONG_HOLD;
				hold_done = 1'b1;
			end else begin
				n = quiet ? 0 : $urandom_range(0, 3);
			end
			@(negedge clk);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	// stimulus and verdict
	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		key_pool[0] = 32'sh80000000;
		key_pool[1] = 32'sh7fffffff;
		key_pool[2] = 32'sh0;
		key_pool[3] = -32'sd1;
		key_pool[4] = 32'sd1;
		for (int i = 5; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// pop smallest: empty read, extremes, update, deletes
		write_pop_max(1'b0);
		send_word(OP_READ, 32'sh0, 32'sh0);
		send_word(OP_WRITE, 32'sh80000000, 32'sd1);
		send_word(OP_WRITE, 32'sh7fffffff, 32'sh80000000);
		send_word(OP_WRITE, 32'sh0, 32'sh7fffffff);
		send_word(OP_WRITE, 32'sh0, -32'sd1);
		send_word(OP_WRITE, 32'sd5, 32'sh0);
		send_word(OP_READ, 32'sh7fffffff, 32'shffffffff);
		send_word(OP_WRITE, 32'sh0, 32'sh0);
		send_word(OP_READ, 32'sh0, 32'sh0);
		send_word(OP_READ, 32'sh0, 32'sh0);
		drain();

		// pop largest
		write_pop_max(1'b1);
		send_word(OP_WRITE, -32'sd1, 32'sd3);
		send_word(OP_WRITE, 32'sd1, 32'sd4);
		send_word(OP_WRITE, 32'sh7fffffff, 32'sd7);
		send_word(OP_WRITE, 32'sh80000000, -32'sd9);
		send_word(OP_READ, 32'sh0, 32'sh0);
		send_word(OP_READ, 32'sh0, 32'sh0);
		send_word(OP_READ, 32'sh0, 32'sh0);
		send_word(OP_READ, 32'sh0, 32'sh0);
		send_word(OP_READ, 32'sh0, 32'sh0);
		drain();

		// random phases: fill, churn and drain under alternating directions
		for (int ph = 0; ph < PHASES; ph++) begin
			write_pop_max((ph % 2) != 0);
			quiet = (ph == 3 || ph == 6);
			if (ph == 2)
				hold_req = 1'b1;
			run_phase(PHASE_WORDS, read_pct[ph]);
			drain();
		end

		$display("Covered %0d words with pops from both ends: %0d pops,", word_count,
			pop_count);
		$display("%0d reads of an empty store, %0d inserts refused by a full store.",
			empty_count, full_count);
		if (fail_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// hard limit on run length
	initial begin : watchdog
		#(LIMIT_CYCLES * 8);
		$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
sv/omp_pkg.sv
sv/omp_cell.sv
sv/omp_chain.sv
sv/ordered_map_pop_min_max_top.sv
verif/omp_checker.sv
verif/tb_ordered_map_pop_min_max_top.sv
